// ===== rtl/core/integer_alu_with_power_unit_assert.svh =====
// Assertion macros shared by the ALU modules.
`ifndef INTEGER_ALU_WITH_POWER_UNIT_ASSERT_SVH
`define INTEGER_ALU_WITH_POWER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define IALU_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define IALU_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ialu_pkg.sv =====
package ialu_pkg;

  // Operand handling: only the low OPERAND_WIDTH bits are used, sign-extended.
  localparam int OPERAND_WIDTH = 32;
  localparam int IN_W          = 32;
  localparam int OP_W          = 3;
  localparam int ST_W          = 3;
  localparam int RES_W         = 64;
  localparam int HALF_W        = RES_W / 2;
  localparam int PROD_W        = RES_W + HALF_W;
  localparam int MUL_W         = HALF_W + 1;
  localparam int CNT_W         = 6;
  localparam int MAX_EXP       = 63;

  // Operator codes.
  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_POW = 3'd4;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_DIV0      = 3'd1;
  localparam logic [ST_W-1:0] ST_ZERO_ZERO = 3'd2;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd3;
  localparam logic [ST_W-1:0] ST_BAD_OP    = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_PLO,
    S_PHI,
    S_PACC,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    PATH_QUICK,
    PATH_DIV,
    PATH_POW
  } path_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic setup;
    logic div_step;
    logic mul_lo;
    logic mul_hi;
    logic pow_acc;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    path_t path;
    logic  cnt_last;
    logic  pow_stop;
  } stat_t;

endpackage

// ===== rtl/core/ialu_dp.sv =====
`include "integer_alu_with_power_unit_assert.svh"

module ialu_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  ialu_pkg::cmd_t               cmd,
  output ialu_pkg::stat_t              stat,
  input  logic [ialu_pkg::OP_W-1:0]    op,
  input  logic [ialu_pkg::IN_W-1:0]    operand_a,
  input  logic [ialu_pkg::IN_W-1:0]    operand_b,
  output logic [ialu_pkg::RES_W-1:0]   result,
  output logic [ialu_pkg::ST_W-1:0]    status
);
  import ialu_pkg::*;

  localparam int W = OPERAND_WIDTH;

  // Captured item.
  logic [OP_W-1:0]         op_r;
  logic signed [W-1:0]     a_r;
  logic signed [W-1:0]     b_r;

  // Working registers.
  logic [RES_W-1:0]        res_r;
  logic [ST_W-1:0]         st_r;
  logic                    neg;
  logic [W-1:0]            mag;
  logic [CNT_W-1:0]        cnt;
  logic [RES_W-1:0]        acc;
  logic [RES_W-1:0]        pl;
  logic [RES_W-1:0]        ph;
  logic [W-1:0]            dvd;
  logic [W-1:0]            rem;
  logic [W-1:0]            quo;

  // Operand decode.
  logic [W-1:0]            a_abs;
  logic [W-1:0]            b_abs;
  logic                    a_neg;
  logic                    b_neg;
  logic                    a_zero;
  logic                    b_zero;
  logic signed [RES_W-1:0] a64;
  logic signed [RES_W-1:0] b64;

  assign a_neg  = a_r[W-1];
  assign b_neg  = b_r[W-1];
  assign a_zero = (a_r == '0);
  assign b_zero = (b_r == '0);
  assign a_abs  = a_neg ? W'(-a_r) : W'(a_r);
  assign b_abs  = b_neg ? W'(-b_r) : W'(b_r);
  assign a64    = RES_W'(a_r);
  assign b64    = RES_W'(b_r);

  // Shared multiplier: signed product for multiply, partial products for power.
  logic signed [MUL_W-1:0]   mx;
  logic signed [MUL_W-1:0]   my;
  logic signed [2*MUL_W-1:0] mprod;

  always_comb begin
    unique if (cmd.mul_lo) begin
      mx = signed'({1'b0, acc[HALF_W-1:0]});
      my = signed'(MUL_W'(mag));
    end else if (cmd.mul_hi) begin
      mx = signed'({1'b0, acc[RES_W-1:HALF_W]});
      my = signed'(MUL_W'(mag));
    end else begin
      mx = MUL_W'(a_r);
      my = MUL_W'(b_r);
    end
  end

  assign mprod = mx * my;

  // Decode of the captured item into a direct result or an iterative path.
  logic [RES_W-1:0] setup_res;
  logic [ST_W-1:0]  setup_st;
  path_t            setup_path;
  logic             setup_neg;
  logic [W-1:0]     setup_mag;
  logic [CNT_W-1:0] setup_cnt;
  logic             pow_neg;
  logic             b_big;

  assign pow_neg = a_neg && b_r[0];
  assign b_big   = !b_neg && (b_abs > W'(MAX_EXP));

  always_comb begin
    setup_res  = '0;
    setup_st   = ST_OK;
    setup_path = PATH_QUICK;
    setup_neg  = 1'b0;
    setup_mag  = a_abs;
    setup_cnt  = b_abs[CNT_W-1:0];
    unique case (op_r)
      OP_ADD: begin
        setup_res = RES_W'(a64 + b64);
      end
      OP_SUB: begin
        setup_res = RES_W'(a64 - b64);
      end
      OP_MUL: begin
        setup_res = mprod[RES_W-1:0];
      end
      OP_DIV: begin
        setup_neg = a_neg ^ b_neg;
        setup_mag = b_abs;
        setup_cnt = CNT_W'(W);
        if (b_zero) begin
          setup_st = ST_DIV0;
        end else begin
          setup_path = PATH_DIV;
        end
      end
      OP_POW: begin
        setup_neg = pow_neg;
        priority if (a_zero && b_zero) begin
          setup_st = ST_ZERO_ZERO;
        end else if (b_neg || b_zero) begin
          setup_res = RES_W'(1);
        end else if (a_zero) begin
          setup_res = '0;
        end else if (a_abs == W'(1)) begin
          setup_res = pow_neg ? '1 : RES_W'(1);
        end else if (b_big) begin
          setup_st = ST_OVERFLOW;
        end else begin
          setup_path = PATH_POW;
        end
      end
      default: begin
        setup_st = ST_BAD_OP;
      end
    endcase
  end

  // One restoring division step on the magnitudes.
  logic [W:0]       rem_sh;
  logic [W:0]       diff;
  logic             take;
  logic [W-1:0]     quo_nx;
  logic [RES_W-1:0] q64;
  logic [RES_W-1:0] div_res;

  assign rem_sh  = {rem, dvd[W-1]};
  assign diff    = rem_sh - {1'b0, mag};
  assign take    = !diff[W];
  assign quo_nx  = {quo[W-2:0], take};
  assign q64     = RES_W'(quo_nx);
  assign div_res = neg ? RES_W'(-q64) : q64;

  // Power accumulate: combine partial products and check the signed range.
  logic [PROD_W-1:0] prod;
  logic [RES_W-1:0]  limit;
  logic              over;
  logic [RES_W-1:0]  pow_val;

  assign prod    = {ph[HALF_W-1:0], {HALF_W{1'b0}}} + {ph[RES_W-1:HALF_W], pl};
  assign limit   = neg ? (RES_W'(1) << (RES_W - 1)) : ~(RES_W'(1) << (RES_W - 1));
  assign over    = (|prod[PROD_W-1:RES_W]) || (prod[RES_W-1:0] > limit);
  assign pow_val = neg ? RES_W'(-prod[RES_W-1:0]) : prod[RES_W-1:0];

  // Status toward the controller.
  assign stat.path     = setup_path;
  assign stat.cnt_last = (cnt == CNT_W'(1));
  assign stat.pow_stop = over || stat.cnt_last;

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r <= op;
      a_r  <= signed'(operand_a[W-1:0]);
      b_r  <= signed'(operand_b[W-1:0]);
    end
    if (cmd.setup) begin
      res_r <= setup_res;
      st_r  <= setup_st;
      neg   <= setup_neg;
      mag   <= setup_mag;
      cnt   <= setup_cnt;
      acc   <= RES_W'(1);
      dvd   <= a_abs;
      rem   <= '0;
      quo   <= '0;
    end
    if (cmd.div_step) begin
      rem <= take ? diff[W-1:0] : rem_sh[W-1:0];
      quo <= quo_nx;
      dvd <= {dvd[W-2:0], 1'b0};
      cnt <= cnt - CNT_W'(1);
      if (stat.cnt_last) begin
        res_r <= div_res;
        st_r  <= ST_OK;
      end
    end
    if (cmd.mul_lo) begin
      pl <= mprod[RES_W-1:0];
    end
    if (cmd.mul_hi) begin
      ph <= mprod[RES_W-1:0];
    end
    if (cmd.pow_acc) begin
      if (over) begin
        res_r <= '0;
        st_r  <= ST_OVERFLOW;
      end else begin
        acc <= prod[RES_W-1:0];
        cnt <= cnt - CNT_W'(1);
        if (stat.cnt_last) begin
          res_r <= pow_val;
          st_r  <= ST_OK;
        end
      end
    end
    if (cmd.load_out) begin
      result <= res_r;
      status <= st_r;
    end
  end

  // A failing status always carries a zero value.
  `IALU_ASSERT_IMP(a_err_zero, clk, rst, cmd.load_out && (st_r != ST_OK), res_r == '0,
    "error status with nonzero result")
  // The partial remainder stays below the divisor.
  `IALU_ASSERT_NEXT(a_rem_below, clk, rst, cmd.div_step, rem < mag,
    "division remainder not below divisor")
  // A kept power step leaves at least the base in the accumulator.
  `IALU_ASSERT_NEXT(a_acc_grows, clk, rst, cmd.pow_acc && !stat.pow_stop, acc > RES_W'(1),
    "power accumulator did not grow")

endmodule

// ===== rtl/core/ialu_ctrl.sv =====
`include "integer_alu_with_power_unit_assert.svh"

module ialu_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  ialu_pkg::stat_t  stat,
  output ialu_pkg::cmd_t   cmd
);
  import ialu_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid flag: set when a result is loaded, cleared when it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        unique case (stat.path)
          PATH_DIV: state_next = S_DIV;
          PATH_POW: state_next = S_PLO;
          default:  state_next = S_FIN;
        endcase
      end
      S_DIV: begin
        if (stat.cnt_last) begin
          state_next = S_FIN;
        end
      end
      S_PLO: begin
        state_next = S_PHI;
      end
      S_PHI: begin
        state_next = S_PACC;
      end
      S_PACC: begin
        state_next = stat.pow_stop ? S_FIN : S_PLO;
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Commands and input ready.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_SETUP: cmd.setup    = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_PLO:   cmd.mul_lo   = 1'b1;
      S_PHI:   cmd.mul_hi   = 1'b1;
      S_PACC:  cmd.pow_acc  = 1'b1;
      S_FIN:   cmd.load_out = out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // A waiting result is never overwritten.
  `IALU_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.load_out, !out_valid || out_ready,
    "result register overwritten")
  // An accepted item goes straight to decode.
  `IALU_ASSERT_NEXT(a_accept_setup, clk, rst, in_valid && in_ready, state == S_SETUP,
    "accepted item did not enter decode")
  // Finishing presents the result and frees the input side.
  `IALU_ASSERT_NEXT(a_fin_done, clk, rst, (state == S_FIN) && out_free,
    out_valid && in_ready, "finish did not present result")

endmodule

// ===== rtl/core/integer_alu_with_power_unit.sv =====
// Channel   Handshake              Fields
// input     in_valid / in_ready    op[2:0], operand_a[31:0], operand_b[31:0]
// output    out_valid / out_ready  result[63:0], status[2:0]
//
// One item is worked at a time. Add, subtract, multiply, errors and trivial
// powers go from decode straight to the finish state; divide steps through
// restoring division, one quotient bit per cycle; power does each multiply in
// low-half, high-half and accumulate states on the shared 33 x 33 multiplier.
// Reset (rst, synchronous) empties the block and the output register.
// A result waiting at the output holds its item; the next item is accepted
// meanwhile and waits in the finish state if the output is still full.
module integer_alu_with_power_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ialu_pkg::OP_W-1:0]   op,
  input  logic [ialu_pkg::IN_W-1:0]   operand_a,
  input  logic [ialu_pkg::IN_W-1:0]   operand_b,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ialu_pkg::RES_W-1:0]  result,
  output logic [ialu_pkg::ST_W-1:0]   status
);
  import ialu_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  ialu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Arithmetic and result registers.
  ialu_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .op        (op),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .result    (result),
    .status    (status)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import ialu_pkg::*;

  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int DRAIN_CYCLES = 250;
  localparam int RANDOM_ITEMS = 1200;

  localparam logic [IN_W-1:0] MOST_NEG = {1'b1, {(IN_W-1){1'b0}}};
  localparam logic [IN_W-1:0] MOST_POS = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic [IN_W-1:0] MINUS_ONE = '1;

  // Operator codes that the block does not know.
  localparam logic [OP_W-1:0] OP_RSV_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_RSV_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_RSV_HI  = 3'd7;

  // One operation waiting to be sent, with its idle gap and a flag that holds
  // it back until every earlier result has come out.
  typedef struct {
    logic [OP_W-1:0] code;
    logic [IN_W-1:0] a;
    logic [IN_W-1:0] b;
    int              gap;
    bit              hold_for_empty;
  } alu_req_t;

  typedef struct {
    logic [RES_W-1:0] value;
    logic [ST_W-1:0]  code;
  } alu_res_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   op = '0;
  logic [IN_W-1:0]   operand_a = '0;
  logic [IN_W-1:0]   operand_b = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [RES_W-1:0]  result;
  logic [ST_W-1:0]   status;

  alu_req_t pending_ops[$];
  alu_res_t expected_results[$];
  int       error_count = 0;
  int       results_seen = 0;
  int       cycle_count = 0;
  int       gap_left = -1;
  int       stall_left = 0;

  integer_alu_with_power_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result),
    .status    (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Only the low OPERAND_WIDTH bits of an operand count, sign-extended.
  function automatic longint sign_fill(logic [IN_W-1:0] raw);
    longint v;
    v = longint'(raw);
    v = v <<< (64 - OPERAND_WIDTH);
    return v >>> (64 - OPERAND_WIDTH);
  endfunction

  // Expected value and status for one operation.
  function automatic alu_res_t predict_alu(logic [OP_W-1:0] code, logic [IN_W-1:0] ra,
                                           logic [IN_W-1:0] rb);
    alu_res_t          r;
    longint            a;
    longint            b;
    longint unsigned   mag;
    longint unsigned   lim;
    longint unsigned   acc;
    bit                neg;
    bit                ovf;
    longint            i;
    a = sign_fill(ra);
    b = sign_fill(rb);
    r.value = '0;
    r.code = ST_OK;
    case (code)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: r.value = a * b;
      OP_DIV: begin
        if (b == 0) r.code = ST_DIV0;
        else r.value = a / b;
      end
      OP_POW: begin
        if (a == 0 && b == 0) begin
          r.code = ST_ZERO_ZERO;
        end else if (b <= 0) begin
          // A negative exponent gives one even for a zero base; a zero exponent gives one for a nonzero base.
          r.value = 64'd1;
        end else begin
          neg = (a < 0) && b[0];
          mag = (a < 0) ? longint'(-a) : a;
          lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
          ovf = 1'b0;
          acc = 64'd1;
          if (mag == 0) begin
            acc = 64'd0;
          end else if (mag != 1) begin
            if (b > MAX_EXP) ovf = 1'b1;
            for (i = 0; i < b && !ovf; i++) begin
              if (acc > lim / mag) ovf = 1'b1;
              else acc = acc * mag;
            end
          end
          if (ovf) r.code = ST_OVERFLOW;
          else r.value = neg ? -acc : acc;
        end
      end
      default: r.code = ST_BAD_OP;
    endcase
    return r;
  endfunction

  // Operand drawn from corners, small values and values of varied magnitude.
  function automatic logic [IN_W-1:0] draw_operand();
    logic [IN_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = '0;
          1: v = 1;
          2: v = MINUS_ONE;
          3: v = MOST_NEG;
          default: v = MOST_POS;
        endcase
      end
      1, 2: v = IN_W'(int'($urandom_range(0, 32)) - 16);
      3, 4: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Idle cycles before an item; the pattern changes every hundred items so
  // that there are busy stretches with no gaps at all.
  function automatic int draw_gap(int idx);
    case ((idx / 100) % 3)
      0: return 0;
      1: return $urandom_range(0, 11);
      default: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 11) : 0;
    endcase
  endfunction

  task automatic queue_op(logic [OP_W-1:0] code, logic [IN_W-1:0] a, logic [IN_W-1:0] b,
                          bit hold);
    alu_req_t req;
    req.code = code;
    req.a = a;
    req.b = b;
    req.gap = draw_gap(pending_ops.size());
    req.hold_for_empty = hold;
    pending_ops.push_back(req);
  endtask

  // Sender: presents the next item after its gap and records the expected
  // result when the item is taken.
  always @(posedge clk) begin
    alu_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_alu(op, operand_a, operand_b));
      end
      if (!(in_valid && !in_ready)) begin
        if (pending_ops.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          if (gap_left < 0) gap_left = pending_ops[0].gap;
          if (gap_left > 0) begin
            gap_left--;
            in_valid <= 1'b0;
          end else if (pending_ops[0].hold_for_empty && expected_results.size() != 0) begin
            in_valid <= 1'b0;
          end else begin
            nxt = pending_ops.pop_front();
            op <= nxt.code;
            operand_a <= nxt.a;
            operand_b <= nxt.b;
            in_valid <= 1'b1;
            gap_left = -1;
          end
        end
      end
    end
  end

  // Receiver: checks each result against the oldest expectation and stalls
  // for a drawn number of cycles after each item.
  always @(posedge clk) begin
    alu_res_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: result with none expected: result %0d status %0d",
                 $time, $signed(result), status);
      end else begin
        exp_r = expected_results.pop_front();
        if (result !== exp_r.value) begin
          error_count++;
          $display("%0t: result mismatch: expected %0d, got %0d",
                   $time, $signed(exp_r.value), $signed(result));
        end
        if (status !== exp_r.code) begin
          error_count++;
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, exp_r.code, status);
        end
      end
      case ((results_seen / 200) % 3)
        0: stall_left = 0;
        1: stall_left = $urandom_range(0, 11);
        default: stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
      endcase
      out_ready <= (stall_left == 0);
    end else if (!out_ready) begin
      if (stall_left > 0) stall_left--;
      if (stall_left == 0) out_ready <= 1'b1;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [OP_W-1:0] code;
    logic [IN_W-1:0] a;
    logic [IN_W-1:0] b;
    int              r;

    // Directed part: field extremes, every operator and the special cases.
    queue_op(OP_ADD, MOST_POS, MOST_POS, 1'b0);
    queue_op(OP_ADD, MOST_NEG, MOST_NEG, 1'b0);
    queue_op(OP_SUB, MOST_NEG, MOST_POS, 1'b0);
    queue_op(OP_MUL, MOST_NEG, MOST_NEG, 1'b0);
    queue_op(OP_MUL, MOST_POS, MOST_NEG, 1'b0);
    queue_op(OP_DIV, 7, -2, 1'b0);
    queue_op(OP_DIV, -7, 2, 1'b0);
    queue_op(OP_DIV, MOST_NEG, MINUS_ONE, 1'b0);
    queue_op(OP_DIV, 5, 0, 1'b0);
    queue_op(OP_POW, 0, 0, 1'b0);
    queue_op(OP_POW, 0, -5, 1'b0);
    queue_op(OP_POW, 5, MOST_NEG, 1'b0);
    queue_op(OP_POW, 2, 62, 1'b0);
    queue_op(OP_POW, 2, 63, 1'b0);
    queue_op(OP_POW, -2, 63, 1'b0);
    queue_op(OP_POW, -2, 64, 1'b0);
    queue_op(OP_POW, MINUS_ONE, MOST_POS, 1'b0);
    queue_op(OP_POW, 1, MOST_POS, 1'b0);
    queue_op(OP_POW, 0, MOST_POS, 1'b0);
    queue_op(OP_POW, 3, 39, 1'b0);
    queue_op(OP_POW, 3, 40, 1'b0);
    queue_op(OP_POW, MOST_NEG, 2, 1'b0);
    queue_op(OP_POW, MOST_NEG, 3, 1'b0);
    queue_op(OP_RSV_LO, MOST_POS, MOST_NEG, 1'b0);
    queue_op(OP_RSV_MID, 0, 0, 1'b0);
    queue_op(OP_RSV_HI, MINUS_ONE, MINUS_ONE, 1'b0);

    // Random part; every three hundred items the sender waits for the
    // block to empty before it goes on.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 94) code = OP_W'(r % (int'(OP_POW) + 1));
      else code = OP_W'($urandom_range(int'(OP_RSV_LO), int'(OP_RSV_HI)));
      a = draw_operand();
      b = draw_operand();
      if (code == OP_DIV && $urandom_range(0, 7) == 0) b = '0;
      if (code == OP_POW) begin
        if ($urandom_range(0, 9) < 7) a = IN_W'(int'($urandom_range(0, 24)) - 12);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: b = $urandom_range(0, 66);
          7: b = IN_W'(-int'($urandom_range(1, 1000)));
          8: b = $urandom;
          default: b = $urandom_range(0, 3);
        endcase
      end
      queue_op(code, a, b, (n % 300) == 0);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
